// ===== hdl/tcc_pkg.sv =====
// shared constants and helpers for the text console cursor
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

  localparam int unsigned ROW_STRIDE_DEF = 80;
  localparam int unsigned TAB_STEP_DEF   = 4;

  localparam int unsigned COORD_W = 8;
  localparam int unsigned ADDR_W  = 15;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR   = 2'd1;

  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST = 8'd80;
  localparam logic [CFG_W-1:0] TEXT_COLOR_RST   = 8'h0F;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_BLANK = 8'h20;

  localparam logic [COORD_W-1:0] ROW_MAX = 8'hFF;

  // row step that holds at the last row
  function automatic logic [COORD_W-1:0] row_inc(input logic [COORD_W-1:0] r);
    row_inc = (r == ROW_MAX) ? ROW_MAX : r + 8'd1;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/text_console_cursor.sv =====
// text console cursor engine: cursor tracking and cell write generation
`timescale 1ns / 1ps
`default_nettype none

// Takes one word per clock: either a character (tuser low) or a cursor move (tuser high).
// Every accepted word yields exactly one registered result word, carrying the cell
// write (if any), the clear request for form feed, and the cursor after the step. The
// cursor column and row live in two registers that update on the accepting edge, so the
// next word sees them at once; the result sits in a single output register, and a new
// word is taken whenever that register is empty or is being drained in the same cycle.
// Sustained rate is one word per cycle, set by the output register handshake.
// The address is column plus row times ROW_STRIDE, kept to 15 bits.

module text_console_cursor
  import tcc_pkg::*;
#(
  parameter int unsigned ROW_STRIDE = ROW_STRIDE_DEF,
  parameter int unsigned TAB_STEP   = TAB_STEP_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [23:0]          s_axis_tdata,  // char_code, new_x, new_y
  input  wire logic                 s_axis_tuser,  // kind
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [47:0]               m_axis_tdata,  // cell_address, cell_value, cursor_col,
                                                   // cursor_row, zero pad
  output logic [1:0]                m_axis_tuser   // cell_write, clear_screen
);

  localparam logic [COORD_W-1:0] STRIDE  = COORD_W'(ROW_STRIDE);
  localparam logic [COORD_W:0]   TAB_INC = (COORD_W+1)'(TAB_STEP);

  logic [CFG_W-1:0]   width_q, color_q;
  logic [COORD_W-1:0] col_q, row_q, col_d, row_d;
  logic               out_valid_q;
  logic [47:0]        out_data_q, out_data_d;
  logic [1:0]         out_user_q, out_user_d;

  logic               s_fire;
  logic [7:0]         char_code, new_x, new_y;
  logic [COORD_W:0]   col_w;
  logic [COORD_W-1:0] row_w, addr_col;
  logic [7:0]         val_char;
  logic               wr, clr;
  logic [15:0]        row_off;
  logic [16:0]        addr_sum;
  logic [ADDR_W-1:0]  cell_addr;
  logic [VALUE_W-1:0] cell_val;

  assign char_code = s_axis_tdata[7:0];
  assign new_x     = s_axis_tdata[15:8];
  assign new_y     = s_axis_tdata[23:16];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    col_w    = {1'b0, col_q};
    row_w    = row_q;
    addr_col = col_q;
    val_char = char_code;
    wr       = 1'b0;
    clr      = 1'b0;
    col_d    = col_q;
    row_d    = row_q;
    if (s_axis_tuser) begin
      col_d = new_x;
      row_d = new_y;
    end else begin
      case (char_code)
        CH_CR, CH_LF: begin
          col_w = '0;
          row_w = row_inc(row_q);
        end
        CH_TAB: begin
          col_w = col_w + TAB_INC;
        end
        CH_VT: begin
          row_w = row_inc(row_q);
        end
        CH_BS: begin
          if (col_q != '0) begin
            col_w    = {1'b0, col_q - 8'd1};
            addr_col = col_q - 8'd1;
            val_char = CH_BLANK;
            wr       = 1'b1;
          end
        end
        CH_FF: begin
          clr   = 1'b1;
          col_w = '0;
          row_w = '0;
        end
        default: begin
          wr    = 1'b1;
          col_w = col_w + 9'd1;
        end
      endcase
      // single wrap step at the screen edge
      if (col_w >= {1'b0, width_q}) begin
        col_w = col_w - {1'b0, width_q};
        row_w = row_inc(row_w);
      end
      col_d = col_w[COORD_W] ? 8'hFF : col_w[COORD_W-1:0];
      row_d = row_w;
    end
  end

  assign row_off   = row_q * STRIDE;
  assign addr_sum  = {1'b0, row_off} + {9'd0, addr_col};
  assign cell_addr = wr ? addr_sum[ADDR_W-1:0] : '0;
  assign cell_val  = wr ? {color_q, val_char} : '0;

  assign out_data_d = {1'b0, row_d, col_d, cell_val, cell_addr};
  assign out_user_d = {clr, wr};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= SCREEN_WIDTH_RST;
      color_q <= TEXT_COLOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SCREEN_WIDTH: width_q <= cfg_data_i;
        REG_TEXT_COLOR:   color_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_fire) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (s_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // cursor move lands exactly where asked
  a_move_sets_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tuser |=> col_q == $past(new_x) && row_q == $past(new_y))
    else $error("cursor move not applied");

  // form feed homes the cursor when the width is nonzero
  a_ff_homes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !s_axis_tuser && char_code == CH_FF && width_q != '0
    |=> col_q == '0 && row_q == '0)
    else $error("form feed did not home cursor");

  // a pending word always reports the current cursor
  a_out_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[38:31] == col_q && m_axis_tdata[46:39] == row_q)
    else $error("output cursor out of step with state");

  // a word never both writes a cell and clears the screen
  a_write_xor_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("cell write and clear in one word");

  // output only becomes valid after an accepted word
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_fire))
    else $error("output valid without input word");

endmodule

`default_nettype wire

// ===== tb/sv/text_console_cursor_test.sv =====
// self-checking testbench for the text console cursor engine
`timescale 1ns / 1ps

module text_console_cursor_test;
  import tcc_pkg::*;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_MOVE = 1'b1;

  typedef struct packed {
    logic               wr;
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] value;
    logic               clr;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } cursor_step_t;

  typedef struct {
    logic         kind;
    logic [7:0]   ch;
    logic [7:0]   x;
    logic [7:0]   y;
    bit           typed;
    cursor_step_t want;
  } console_cmd_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata;  // char_code, new_x, new_y
  logic                 s_axis_tuser;  // kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [47:0]          m_axis_tdata;  // cell_address, cell_value, cursor_col, cursor_row, pad
  logic [1:0]           m_axis_tuser;  // cell_write, clear_screen

  // predicted cursor and register copies
  logic [COORD_W-1:0] cur_col;
  logic [COORD_W-1:0] cur_row;
  logic [CFG_W-1:0]   cfg_width;
  logic [CFG_W-1:0]   cfg_color;

  cursor_step_t pending_steps[$];
  console_cmd_t script[$];
  cursor_step_t got_step;
  int unsigned  mismatches;
  int unsigned  results_seen;
  bit           calm;

  text_console_cursor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int bump_row(int r);
    return (r >= 255) ? 255 : r + 1;
  endfunction

  // one console step on the predicted cursor
  function automatic cursor_step_t advance_cursor(logic kind, logic [7:0] ch,
                                                  logic [7:0] x, logic [7:0] y);
    cursor_step_t r;
    int col;
    int row;
    r = '0;
    col = cur_col;
    row = cur_row;
    if (kind == KIND_MOVE) begin
      col = x;
      row = y;
    end else begin
      case (ch)
        CH_CR, CH_LF: begin
          col = 0;
          row = bump_row(row);
        end
        CH_TAB: col = col + TAB_STEP_DEF;
        CH_VT: row = bump_row(row);
        CH_BS: begin
          if (col > 0) begin
            col = col - 1;
            r.wr = 1'b1;
            r.addr = ADDR_W'(col + row * ROW_STRIDE_DEF);
            r.value = {cfg_color, CH_BLANK};
          end
        end
        CH_FF: begin
          r.clr = 1'b1;
          col = 0;
          row = 0;
        end
        default: begin
          r.wr = 1'b1;
          r.addr = ADDR_W'(col + row * ROW_STRIDE_DEF);
          r.value = {cfg_color, ch};
          col = col + 1;
        end
      endcase
      if (col >= int'(cfg_width)) begin
        col = col - int'(cfg_width);
        row = bump_row(row);
      end
      if (col > 255) col = 255;
    end
    cur_col = COORD_W'(col);
    cur_row = COORD_W'(row);
    r.col = cur_col;
    r.row = cur_row;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_steps.size() == 0) begin
        $error("result word with no expectation pending");
        mismatches++;
      end else begin
        got_step = pending_steps.pop_front();
        check_field("cell_write", got_step.wr, m_axis_tuser[0]);
        check_field("clear_screen", got_step.clr, m_axis_tuser[1]);
        check_field("cell_address", got_step.addr, m_axis_tdata[14:0]);
        check_field("cell_value", got_step.value, m_axis_tdata[30:15]);
        check_field("cursor_col", got_step.col, m_axis_tdata[38:31]);
        check_field("cursor_row", got_step.row, m_axis_tdata[46:39]);
      end
    end
  end

  // receiver side: random stalls plus one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held && results_seen >= 140) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (60) @(negedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  task automatic add_row(logic kind, logic [7:0] ch, logic [7:0] x, logic [7:0] y, bit typed,
                         logic wr, int addr, int value, logic clr, int col, int row);
    console_cmd_t c;
    c.kind = kind;
    c.ch = ch;
    c.x = x;
    c.y = y;
    c.typed = typed;
    c.want = '{wr, ADDR_W'(addr), VALUE_W'(value), clr, COORD_W'(col), COORD_W'(row)};
    script.push_back(c);
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer_word(logic kind, logic [7:0] ch, logic [7:0] x, logic [7:0] y,
                            bit typed, cursor_step_t typed_want);
    cursor_step_t want;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {y, x, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    want = advance_cursor(kind, ch, x, y);
    pending_steps.push_back(typed ? typed_want : want);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_config(logic [CFG_W-1:0] width, logic [CFG_W-1:0] color);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_SCREEN_WIDTH;
    cfg_data_i <= width;
    @(negedge clk_i);
    cfg_width = width;
    cfg_index_i <= REG_TEXT_COLOR;
    cfg_data_i <= color;
    @(negedge clk_i);
    cfg_color = color;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_coord();
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r < 2) return 8'hFF;
    if (r == 2) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic pick_random(output logic kind, output logic [7:0] ch,
                             output logic [7:0] x, output logic [7:0] y);
    logic [7:0] ctl[6];
    int unsigned r;
    ctl = '{CH_CR, CH_LF, CH_TAB, CH_VT, CH_BS, CH_FF};
    r = $urandom_range(0, 99);
    kind = KIND_CHAR;
    ch = 8'($urandom_range(0, 255));
    x = 8'($urandom_range(0, 255));
    y = 8'($urandom_range(0, 255));
    if (r < 12) begin
      kind = KIND_MOVE;
      x = pick_coord();
      y = pick_coord();
    end else if (r < 40) begin
      ch = ctl[$urandom_range(0, 5)];
    end
  endtask

  initial begin
    logic [CFG_W-1:0] widths[5];
    logic [CFG_W-1:0] colors[5];
    logic kind;
    logic [7:0] ch;
    logic [7:0] x;
    logic [7:0] y;
    widths = '{SCREEN_WIDTH_RST, 8'd255, 8'd1, 8'd0, 8'd80};
    colors = '{TEXT_COLOR_RST, 8'h00, 8'hFF, 8'hA5, 8'h0F};
    widths[4] = 8'($urandom_range(1, 255));
    colors[4] = 8'($urandom_range(0, 255));
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cur_col = '0;
    cur_row = '0;
    cfg_width = SCREEN_WIDTH_RST;
    cfg_color = TEXT_COLOR_RST;
    mismatches = 0;
    results_seen = 0;
    calm = 1'b0;

    add_row(KIND_CHAR, 8'h41, 8'h00, 8'h00, 1, 1, 0, 16'h0F41, 0, 1, 0);
    add_row(KIND_CHAR, CH_BS, 8'h00, 8'h00, 1, 1, 0, 16'h0F20, 0, 0, 0);
    add_row(KIND_CHAR, CH_BS, 8'h00, 8'h00, 1, 0, 0, 0, 0, 0, 0);
    add_row(KIND_CHAR, CH_TAB, 8'h00, 8'h00, 1, 0, 0, 0, 0, 4, 0);
    add_row(KIND_CHAR, CH_CR, 8'h00, 8'h00, 1, 0, 0, 0, 0, 0, 1);
    add_row(KIND_CHAR, CH_LF, 8'h00, 8'h00, 1, 0, 0, 0, 0, 0, 2);
    add_row(KIND_CHAR, CH_VT, 8'h00, 8'h00, 1, 0, 0, 0, 0, 0, 3);
    add_row(KIND_MOVE, 8'hFF, 8'd79, 8'd3, 1, 0, 0, 0, 0, 79, 3);
    add_row(KIND_CHAR, 8'hFF, 8'h00, 8'h00, 1, 1, 319, 16'h0FFF, 0, 0, 4);
    add_row(KIND_MOVE, 8'h00, 8'hFF, 8'hFF, 1, 0, 0, 0, 0, 255, 255);
    add_row(KIND_CHAR, 8'h00, 8'h00, 8'h00, 1, 1, 20655, 16'h0F00, 0, 176, 255);
    add_row(KIND_CHAR, CH_TAB, 8'h00, 8'h00, 1, 0, 0, 0, 0, 100, 255);
    add_row(KIND_CHAR, CH_LF, 8'h00, 8'h00, 1, 0, 0, 0, 0, 0, 255);
    add_row(KIND_CHAR, CH_FF, 8'h00, 8'h00, 1, 0, 0, 0, 1, 0, 0);
    add_row(KIND_MOVE, CH_FF, 8'd78, 8'd0, 1, 0, 0, 0, 0, 78, 0);
    add_row(KIND_CHAR, CH_TAB, 8'h00, 8'h00, 1, 0, 0, 0, 0, 2, 1);
    add_row(KIND_CHAR, 8'h7A, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0, 0);
    add_row(KIND_CHAR, 8'h80, 8'hFF, 8'hFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(KIND_MOVE, 8'h55, 8'hAA, 8'h55, 0, 0, 0, 0, 0, 0, 0);
    add_row(KIND_CHAR, CH_BS, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0, 0);
    add_row(KIND_CHAR, 8'h7E, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0, 0);
    add_row(KIND_MOVE, CH_BS, 8'h00, 8'h00, 1, 0, 0, 0, 0, 0, 0);
    add_row(KIND_CHAR, CH_CR, 8'h00, 8'h00, 1, 0, 0, 0, 0, 0, 1);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[i])
      offer_word(script[i].kind, script[i].ch, script[i].x, script[i].y,
                 script[i].typed, script[i].want);

    for (int phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        drain_results();
        set_config(widths[phase], colors[phase]);
      end
      calm = (phase == 4);
      // push the column past the width near the last row
      offer_word(KIND_MOVE, 8'h00, 8'hFF, 8'hFE, 0, '0);
      offer_word(KIND_CHAR, CH_TAB, 8'h00, 8'h00, 0, '0);
      offer_word(KIND_CHAR, 8'h5A, 8'h00, 8'h00, 0, '0);
      for (int n = 0; n < 75; n++) begin
        pick_random(kind, ch, x, y);
        offer_word(kind, ch, x, y, 0, '0);
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tcc_pkg.sv
hdl/text_console_cursor.sv
tb/sv/text_console_cursor_test.sv
